// ----- hdl/whs_pkg.sv -----
`default_nettype none

package whs_pkg;

  // Pipeline shape
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_STAGES    = CORDIC_STAGES + 3;
  localparam int CORD_W        = 20;

  // Heading error dead band, binary angle units
  localparam int ANGLE_TOLERANCE = 1820;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_X      = 3'd0;
  localparam logic [2:0] REG_TARGET_Y      = 3'd1;
  localparam logic [2:0] REG_FAST_MODE     = 3'd2;
  localparam logic [2:0] REG_REACH_MARGIN  = 3'd3;
  localparam logic [2:0] REG_FWD_SPEED     = 3'd4;
  localparam logic [2:0] REG_FAST_FWD      = 3'd5;
  localparam logic [2:0] REG_SPIN_SPEED    = 3'd6;
  localparam logic [2:0] REG_FAST_SPIN     = 3'd7;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_FORWARD    = 2'd1,
    ACT_SPIN_LEFT  = 2'd2,
    ACT_SPIN_RIGHT = 2'd3
  } action_e;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        heading;
  } whs_in_t;

  typedef struct packed {
    logic               reached;
    logic [1:0]         action;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } whs_out_t;

  // Offset stage payload
  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        heading;
  } whs_ofs_t;

  // CORDIC stage payload
  typedef struct packed {
    logic                     reached;
    logic                     zero;
    logic [15:0]              heading;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic [31:0]              z;
  } whs_cord_t;

endpackage

`default_nettype wire

// ----- hdl/waypoint_heading_steering_top.sv -----
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------
// in       | input     | in_valid_i / in_stall_o   | in_data_i  (pos_x, pos_y, heading)
// out      | output    | out_valid_o / out_stall_i | out_data_o (reached, action, speeds)
// cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One transaction can enter every cycle while in_stall_o is low; the registers
// are, in order: offset stage, pre-rotation stage, one register per
// CORDIC iteration, and the decision/output register.
// Each stage holds its own valid bit and loads when it is empty or its successor
// can take its data, so bubbles collapse under stall and no transaction is lost or repeated.
// Reset clears all valid bits and the configuration registers.

module waypoint_heading_steering_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire whs_pkg::whs_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output whs_pkg::whs_out_t     out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [15:0]      cfg_data_i
);
  import whs_pkg::*;

  localparam logic signed [16:0] TOL = 17'(ANGLE_TOLERANCE);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [15:0] target_x_q, target_y_q;
  logic               fast_mode_q;
  logic [14:0]        reach_margin_q, fwd_speed_q, fast_fwd_q, spin_speed_q, fast_spin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q     <= '0;
      target_y_q     <= '0;
      fast_mode_q    <= 1'b0;
      reach_margin_q <= '0;
      fwd_speed_q    <= '0;
      fast_fwd_q     <= '0;
      spin_speed_q   <= '0;
      fast_spin_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_X:     target_x_q     <= cfg_data_i;
        REG_TARGET_Y:     target_y_q     <= cfg_data_i;
        REG_FAST_MODE:    fast_mode_q    <= cfg_data_i[0];
        REG_REACH_MARGIN: reach_margin_q <= cfg_data_i[14:0];
        REG_FWD_SPEED:    fwd_speed_q    <= cfg_data_i[14:0];
        REG_FAST_FWD:     fast_fwd_q     <= cfg_data_i[14:0];
        REG_SPIN_SPEED:   spin_speed_q   <= cfg_data_i[14:0];
        REG_FAST_SPIN:    fast_spin_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and per-stage load enables
  // bit 0: offset stage, bits 1..CORDIC_STAGES+1: CORDIC chain, last: output
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: per-axis offsets to target (17 bit)
  // ---------------------------------------------------------------------------
  whs_ofs_t ofs_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ofs_q.dx      <= 17'(target_x_q) - 17'(in_data_i.pos_x);
      ofs_q.dy      <= 17'(target_y_q) - 17'(in_data_i.pos_y);
      ofs_q.heading <= in_data_i.heading;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: reach test and pre-rotation into the right half plane
  // ---------------------------------------------------------------------------
  whs_cord_t cord_q [CORDIC_STAGES+1];
  logic [16:0] adx, ady;

  assign adx = ofs_q.dx[16] ? 17'(-ofs_q.dx) : ofs_q.dx;
  assign ady = ofs_q.dy[16] ? 17'(-ofs_q.dy) : ofs_q.dy;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      cord_q[0].reached <= (adx < {2'b00, reach_margin_q}) && (ady < {2'b00, reach_margin_q});
      cord_q[0].zero    <= (ofs_q.dx == '0) && (ofs_q.dy == '0);
      cord_q[0].heading <= ofs_q.heading;
      if (ofs_q.dx[16]) begin
        // left half plane: rotate by a half turn
        cord_q[0].x <= -CORD_W'(ofs_q.dx);
        cord_q[0].y <= -CORD_W'(ofs_q.dy);
        cord_q[0].z <= 32'h8000_0000;
      end else begin
        cord_q[0].x <= CORD_W'(ofs_q.dx);
        cord_q[0].y <= CORD_W'(ofs_q.dy);
        cord_q[0].z <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: one registered micro-rotation per stage
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (rdy[k+2]) begin
        cord_q[k+1].reached <= cord_q[k].reached;
        cord_q[k+1].zero    <= cord_q[k].zero;
        cord_q[k+1].heading <= cord_q[k].heading;
        if (!cord_q[k].y[CORD_W-1]) begin
          cord_q[k+1].x <= cord_q[k].x + (cord_q[k].y >>> k);
          cord_q[k+1].y <= cord_q[k].y - (cord_q[k].x >>> k);
          cord_q[k+1].z <= cord_q[k].z + ATAN_TURNS[k];
        end else begin
          cord_q[k+1].x <= cord_q[k].x - (cord_q[k].y >>> k);
          cord_q[k+1].y <= cord_q[k].y + (cord_q[k].x >>> k);
          cord_q[k+1].z <= cord_q[k].z - ATAN_TURNS[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage: round bearing, wrapped heading error, bang-bang decision
  // ---------------------------------------------------------------------------
  whs_cord_t          fin;
  logic [31:0]        z_rnd;
  logic [15:0]        bearing;
  logic signed [15:0] err;
  logic signed [16:0] err_x;
  logic [14:0]        fwd_spd, spn_spd;
  logic signed [15:0] fwd_s, spn_s;
  whs_out_t           res;
  whs_out_t           out_q;

  assign fin     = cord_q[CORDIC_STAGES];
  assign z_rnd   = fin.z + 32'h0000_8000;
  // zero offset: bearing defined as 0
  assign bearing = fin.zero ? 16'h0000 : z_rnd[31:16];
  assign err     = bearing - fin.heading;
  assign err_x   = 17'(err);
  assign fwd_spd = fast_mode_q ? fast_fwd_q : fwd_speed_q;
  assign spn_spd = fast_mode_q ? fast_spin_q : spin_speed_q;
  assign fwd_s   = {1'b0, fwd_spd};
  assign spn_s   = {1'b0, spn_spd};

  always_comb begin
    res = '0;
    if (fin.reached) begin
      res.reached = 1'b1;
      res.action  = ACT_NONE;
    end else if (err_x > TOL) begin
      res.action      = ACT_SPIN_LEFT;
      res.left_speed  = -spn_s;
      res.right_speed = spn_s;
    end else if (err_x < -TOL) begin
      // a half-turn error lands here as well
      res.action      = ACT_SPIN_RIGHT;
      res.left_speed  = spn_s;
      res.right_speed = -spn_s;
    end else begin
      res.action      = ACT_FORWARD;
      res.left_speed  = fwd_s;
      res.right_speed = fwd_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NUM_STAGES-1]) begin
      out_q <= res;
    end
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  a_reached_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reached) |->
      (out_data_o.action == ACT_NONE && out_data_o.left_speed == '0 &&
       out_data_o.right_speed == '0))
    else $error("command issued with target reached");

  a_cmd_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.reached) |-> (out_data_o.action != ACT_NONE))
    else $error("no command while target not reached");

  a_forward_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == ACT_FORWARD) |->
      (out_data_o.left_speed == out_data_o.right_speed))
    else $error("forward with unequal wheel speeds");

  a_spin_opposed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.action == ACT_SPIN_LEFT ||
                     out_data_o.action == ACT_SPIN_RIGHT)) |->
      (out_data_o.left_speed == -out_data_o.right_speed))
    else $error("spin with non-opposed wheel speeds");

endmodule

`default_nettype wire
